// ===== rtl/fpwsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpwsb_pkg: shared types and constants of the page write staging buffer
// Page geometry, request codes and the structs passed between the
// staging logic, the byte banks and the top level.
// ----------------------------------------------------------------------------
package fpwsb_pkg;

   // Page geometry (page size is a power of two)
   localparam int PAGE_BYTES = 512;
   localparam int ADDR_BITS  = 16;
   localparam int OFF_BITS   = $clog2(PAGE_BYTES);
   localparam int ROW_BITS   = OFF_BITS - 1;
   localparam int ROWS       = PAGE_BYTES / 2;
   localparam int PAGE_BITS  = ADDR_BITS - OFF_BITS;

   // Each bank entry holds an epoch tag over the staged byte
   localparam int EPOCH_BITS  = 8;
   localparam int ENTRY_BITS  = EPOCH_BITS + 8;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

   // Request codes
   typedef logic [2:0] req_code_type;
   localparam req_code_type REQ_WRITE_BYTE = 3'd0;
   localparam req_code_type REQ_WRITE_WORD = 3'd1;
   localparam req_code_type REQ_READ_BYTE  = 3'd2;
   localparam req_code_type REQ_READ_WORD  = 3'd3;
   localparam req_code_type REQ_COMMIT     = 3'd4;

   typedef struct packed {
      req_code_type           req_type;
      logic [ADDR_BITS-1:0]   address;
      logic [15:0]            write_data;
      logic [15:0]            flash_data;
   } req_beat_type;

   typedef struct packed {
      logic                   pending;
      logic                   claimed;
      logic [PAGE_BITS-1:0]   page;
      logic [EPOCH_BITS-1:0]  epoch;
   } stage_state_type;

   typedef struct packed {
      logic                   we;
      logic [ROW_BITS-1:0]    row;
      logic [7:0]             data;
   } bank_wr_type;

   typedef struct packed {
      logic                   status;
      logic [15:0]            read_data;
      logic [6:0]             page_number;
      logic                   clear_start;
      stage_state_type        next_state;
      bank_wr_type            wr_even;
      bank_wr_type            wr_odd;
   } merge_result_type;

endpackage
`default_nettype wire

// ===== rtl/fpwsb_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpwsb_bank: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpwsb_bank #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write a row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read a row, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fpwsb_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpwsb_merge: staging decision for one request beat
// Merges buffered and flash bytes for reads, decides claim, busy and byte
// staging for writes, and computes the next page state.
// ----------------------------------------------------------------------------
module fpwsb_merge
   import fpwsb_pkg::*;
(
   input  wire req_beat_type               beat,
   input  wire stage_state_type            state,
   input  wire logic [ENTRY_BITS-1:0]      even_entry,
   input  wire logic [ENTRY_BITS-1:0]      odd_entry,
   input  wire bank_wr_type                fwd_even,
   input  wire bank_wr_type                fwd_odd,
   output merge_result_type                result
);

   logic [ADDR_BITS-1:0]  addr_a;
   logic [ADDR_BITS-1:0]  addr_n;
   logic [PAGE_BITS-1:0]  page_a;
   logic [PAGE_BITS-1:0]  page_n;
   logic [ROW_BITS-1:0]   row_a;
   logic [ROW_BITS-1:0]   row_n;
   logic                  a_even;
   logic [ENTRY_BITS-1:0] ent_a;
   logic [ENTRY_BITS-1:0] ent_n;
   bank_wr_type           fw_a;
   bank_wr_type           fw_n;
   logic                  fhit_a;
   logic                  fhit_n;
   logic                  dirty_a;
   logic                  dirty_n;
   logic [7:0]            buf_a;
   logic [7:0]            buf_n;
   logic [7:0]            rd_a;
   logic [7:0]            rd_n;
   logic [7:0]            rd_b;
   logic                  ch1;
   logic                  ch2;
   logic                  busy1;
   logic                  busy2;
   logic                  stg1;
   logic                  stg2;
   logic                  claimed1;
   logic [PAGE_BITS-1:0]  page1;
   logic                  we_a;
   logic                  we_n;
   logic [7:0]            wbyte_a;
   logic [7:0]            wbyte_n;
   logic                  status;
   logic [15:0]           read_data;
   stage_state_type       nxt;
   logic                  clear_start;
   logic [6:0]            page_ext;

   // Split the address into page and bank row for both bytes
   assign addr_a = beat.address;
   assign addr_n = addr_a + ADDR_BITS'(1);
   assign page_a = addr_a[ADDR_BITS-1:OFF_BITS];
   assign page_n = addr_n[ADDR_BITS-1:OFF_BITS];
   assign row_a  = addr_a[OFF_BITS-1:1];
   assign row_n  = addr_n[OFF_BITS-1:1];
   assign a_even = !addr_a[0];

   // Pick bank entries and bypass the write of the previous beat
   assign ent_a   = a_even ? even_entry : odd_entry;
   assign ent_n   = a_even ? odd_entry : even_entry;
   assign fw_a    = a_even ? fwd_even : fwd_odd;
   assign fw_n    = a_even ? fwd_odd : fwd_even;
   assign fhit_a  = fw_a.we && (fw_a.row == row_a);
   assign fhit_n  = fw_n.we && (fw_n.row == row_n);
   assign dirty_a = fhit_a || (ent_a[ENTRY_BITS-1:8] == state.epoch);
   assign dirty_n = fhit_n || (ent_n[ENTRY_BITS-1:8] == state.epoch);
   assign buf_a   = fhit_a ? fw_a.data : ent_a[7:0];
   assign buf_n   = fhit_n ? fw_n.data : ent_n[7:0];

   // Merge reads per byte; a byte read merges the byte at the address
   // against the low flash byte
   always_comb begin
      rd_a = beat.flash_data[15:8];
      rd_n = beat.flash_data[7:0];
      rd_b = beat.flash_data[7:0];
      if (state.pending && state.claimed && (state.page == page_a) && dirty_a) begin
         rd_a = buf_a;
         rd_b = buf_a;
      end
      if (state.pending && state.claimed && (state.page == page_n) && dirty_n) begin
         rd_n = buf_n;
      end
   end

   // Split write: low byte at next address first, then high byte at address
   always_comb begin
      ch1      = beat.write_data[7:0] != beat.flash_data[7:0];
      busy1    = ch1 && state.claimed && (state.page != page_n);
      stg1     = ch1 && !busy1;
      claimed1 = state.claimed || stg1;
      page1    = (!state.claimed && stg1) ? page_n : state.page;
      ch2      = beat.write_data[15:8] != beat.flash_data[15:8];
      busy2    = !busy1 && ch2 && claimed1 && (page1 != page_a);
      stg2     = !busy1 && ch2 && !busy2;
   end

   // Decide staging, status and next page state
   always_comb begin
      nxt         = state;
      we_a        = 1'b0;
      we_n        = 1'b0;
      wbyte_a     = beat.write_data[15:8];
      wbyte_n     = beat.write_data[7:0];
      status      = 1'b0;
      read_data   = 16'h0000;
      clear_start = 1'b0;
      case (beat.req_type)
         REQ_WRITE_BYTE: begin
            wbyte_a = beat.write_data[7:0];
            if (beat.write_data[7:0] != beat.flash_data[7:0]) begin
               if (state.claimed && (state.page != page_a)) begin
                  status = 1'b1;
               end else begin
                  we_a        = 1'b1;
                  nxt.claimed = 1'b1;
                  nxt.page    = page_a;
               end
            end
         end
         REQ_WRITE_WORD: begin
            if (a_even && (page_a == page_n)) begin
               if (beat.write_data != beat.flash_data) begin
                  if (state.claimed && (state.page != page_a)) begin
                     status = 1'b1;
                  end else begin
                     we_a        = 1'b1;
                     we_n        = 1'b1;
                     nxt.claimed = 1'b1;
                     nxt.page    = page_a;
                  end
               end
            end else begin
               status      = busy1 || busy2;
               we_n        = stg1;
               we_a        = stg2;
               nxt.claimed = claimed1 || stg2;
               nxt.page    = (!claimed1 && stg2) ? page_a : page1;
            end
         end
         REQ_READ_BYTE: begin
            read_data = {8'h00, rd_b};
         end
         REQ_READ_WORD: begin
            read_data = {rd_a, rd_n};
         end
         REQ_COMMIT: begin
            nxt.pending = 1'b0;
            nxt.claimed = 1'b0;
            nxt.page    = '0;
            if (&state.epoch) begin
               nxt.epoch   = EPOCH_FIRST;
               clear_start = 1'b1;
            end else begin
               nxt.epoch = state.epoch + EPOCH_BITS'(1);
            end
         end
         default: begin
         end
      endcase
      if (we_a || we_n) begin
         nxt.pending = 1'b1;
      end
   end

   // Report the claimed page number
   assign page_ext = 7'(nxt.page);

   // Route byte writes to the bank of their parity
   always_comb begin
      result             = '0;
      result.status      = status;
      result.read_data   = read_data;
      result.page_number = page_ext;
      result.clear_start = clear_start;
      result.next_state  = nxt;
      if (a_even) begin
         result.wr_even = '{we: we_a, row: row_a, data: wbyte_a};
         result.wr_odd  = '{we: we_n, row: row_n, data: wbyte_n};
      end else begin
         result.wr_even = '{we: we_n, row: row_n, data: wbyte_n};
         result.wr_odd  = '{we: we_a, row: row_a, data: wbyte_a};
      end
   end

endmodule
`default_nettype wire

// ===== rtl/flash_page_write_staging_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flash_page_write_staging_buffer: staging buffer for one flash page
// Usage:
//   Requests arrive on the req_ channel (valid/ready) with the access type,
//   byte address, write data and the current flash contents at the address.
//   Each request gives exactly one beat on the rsp_ channel: status, merged
//   read data, pending flag and claimed page number.
//   A request passes through the input register, where the byte banks are
//   read, and then through the staging decision into the result register.
//   One request is taken every cycle while no stall or clearing pass
//   holds it; the byte banks (even and odd byte, one write and one read
//   port each) let a word access touch both bytes at once.
//   A stalled receiver holds the result register; the stage behind it fills
//   and then req_ready drops until the result beat is taken.
//   The staged bytes carry an epoch tag so commit frees the mask at once.
//   After reset, and after every 255th commit, a clearing pass rewrites the
//   tags of all 256 rows, during which req_ready is low.
//   Reset is synchronous and active high; it frees the page and the mask.
// ----------------------------------------------------------------------------
module flash_page_write_staging_buffer
   import fpwsb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [15:0] req_address,
   input  wire logic [15:0] req_write_data,
   input  wire logic [15:0] req_flash_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [15:0]      rsp_read_data,
   output logic             rsp_pending,
   output logic [6:0]       rsp_page_number
);

   req_beat_type            s2_beat_ff;
   logic                    s2_valid_ff;
   stage_state_type         state_ff;
   logic                    clr_active_ff;
   logic [ROW_BITS-1:0]     clr_row_ff;
   bank_wr_type             fwd_even_ff;
   bank_wr_type             fwd_odd_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_status_ff;
   logic [15:0]             rsp_read_data_ff;
   logic                    rsp_pending_ff;
   logic [6:0]              rsp_page_number_ff;

   merge_result_type        mres;
   logic                    s2_advance;
   logic                    accept;
   logic [ADDR_BITS-1:0]    req_next;
   logic [ROW_BITS-1:0]     rd_row_even;
   logic [ROW_BITS-1:0]     rd_row_odd;
   logic [ENTRY_BITS-1:0]   even_entry;
   logic [ENTRY_BITS-1:0]   odd_entry;
   bank_wr_type             wr_even_in;
   bank_wr_type             wr_odd_in;
   logic [ENTRY_BITS-1:0]   wdata_even;
   logic [ENTRY_BITS-1:0]   wdata_odd;

   // Handshake: advance into the result register, block during clearing
   assign s2_advance = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !clr_active_ff &&
                       (!s2_valid_ff || (s2_advance && !mres.clear_start));
   assign accept     = req_valid && req_ready;

   // Bank read rows of the byte at the address and the next one
   assign req_next    = req_address + ADDR_BITS'(1);
   assign rd_row_even = req_address[0] ? req_next[OFF_BITS-1:1]
                                       : req_address[OFF_BITS-1:1];
   assign rd_row_odd  = req_address[0] ? req_address[OFF_BITS-1:1]
                                       : req_next[OFF_BITS-1:1];

   // Bank writes: clearing pass or staged bytes of the finishing beat
   always_comb begin
      if (clr_active_ff) begin
         wr_even_in = '{we: 1'b1, row: clr_row_ff, data: 8'h00};
         wr_odd_in  = '{we: 1'b1, row: clr_row_ff, data: 8'h00};
         wdata_even = '0;
         wdata_odd  = '0;
      end else begin
         wr_even_in    = mres.wr_even;
         wr_odd_in     = mres.wr_odd;
         wr_even_in.we = mres.wr_even.we && s2_advance;
         wr_odd_in.we  = mres.wr_odd.we && s2_advance;
         wdata_even    = {state_ff.epoch, mres.wr_even.data};
         wdata_odd     = {state_ff.epoch, mres.wr_odd.data};
      end
   end

   fpwsb_bank #(
      .DEPTH (ROWS),
      .WIDTH (ENTRY_BITS)
   ) u_bank_even (
      .clock   (clock),
      .wr_en   (wr_even_in.we),
      .wr_addr (wr_even_in.row),
      .wr_data (wdata_even),
      .rd_en   (accept),
      .rd_addr (rd_row_even),
      .rd_data (even_entry)
   );

   fpwsb_bank #(
      .DEPTH (ROWS),
      .WIDTH (ENTRY_BITS)
   ) u_bank_odd (
      .clock   (clock),
      .wr_en   (wr_odd_in.we),
      .wr_addr (wr_odd_in.row),
      .wr_data (wdata_odd),
      .rd_en   (accept),
      .rd_addr (rd_row_odd),
      .rd_data (odd_entry)
   );

   fpwsb_merge u_merge (
      .beat       (s2_beat_ff),
      .state      (state_ff),
      .even_entry (even_entry),
      .odd_entry  (odd_entry),
      .fwd_even   (fwd_even_ff),
      .fwd_odd    (fwd_odd_ff),
      .result     (mres)
   );

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_beat_ff <= '{req_type: req_type, address: req_address,
                         write_data: req_write_data, flash_data: req_flash_data};
      end
   end

   // Track the decision stage, bypass records and page state
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_even_ff <= '0;
         fwd_odd_ff  <= '0;
         state_ff    <= '{pending: 1'b0, claimed: 1'b0, page: '0, epoch: EPOCH_FIRST};
      end else begin
         if (accept) begin
            s2_valid_ff <= 1'b1;
            fwd_even_ff <= wr_even_in;
            fwd_odd_ff  <= wr_odd_in;
         end else if (s2_advance) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_advance) begin
            state_ff <= mres.next_state;
         end
      end
   end

   // Sweep the bank tags after reset and on epoch wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else if (s2_advance && mres.clear_start) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_row_ff <= clr_row_ff + ROW_BITS'(1);
         if (&clr_row_ff) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_advance) begin
         rsp_status_ff      <= mres.status;
         rsp_read_data_ff   <= mres.read_data;
         rsp_pending_ff     <= mres.next_state.pending;
         rsp_page_number_ff <= mres.page_number;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_pending     = rsp_pending_ff;
   assign rsp_page_number = rsp_page_number_ff;

`ifndef SYNTHESIS
   a_clear_stage_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s2_valid_ff)
      else $error("request in flight during tag clearing pass");

   a_pending_claimed: assert property (@(posedge clock) disable iff (reset)
      state_ff.pending |-> state_ff.claimed)
      else $error("staged changes without a claimed page");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.epoch != '0)
      else $error("epoch reached the cleared tag value");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s2_advance |=> rsp_valid)
      else $error("finished request gave no result beat");
`endif

endmodule
`default_nettype wire
